// File: rtl/core/cal_pkg.sv
package cal_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int DATA_WIDTH  = 8;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 6;
  localparam int CMP_W       = CNT_W + CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(63);

  typedef enum logic [3:0] {
    OP_INSERT  = 4'd0,
    OP_REMOVE  = 4'd1,
    OP_REPLACE = 4'd2,
    OP_CLEAR   = 4'd3,
    OP_BEGIN   = 4'd4,
    OP_END     = 4'd5,
    OP_NEXT    = 4'd6,
    OP_PRIOR   = 4'd7,
    OP_READ    = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic accept;
    logic shift_step;
    logic place;
    logic fetch;
    logic load_out;
  } cal_cmd_t;

  typedef struct packed {
    logic need_shift;
    logic need_place;
    logic shift_active;
    logic place_pending;
    logic out_free;
  } cal_stat_t;

endpackage

// File: rtl/core/cal_ram.sv
module cal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/cal_datapath.sv
module cal_datapath
  import cal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [3:0]              op,
  input  logic [7:0]              item,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_data,
  input  cal_cmd_t                cmd,
  output cal_stat_t               stat,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic signed [6:0]       cursor_position,
  output logic [7:0]              read_value,
  output logic [5:0]              entry_count,
  output logic                    is_full,
  output logic                    is_empty
);

  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      total;
  logic [IDX_W-1:0]      cursor;
  logic [IDX_W-1:0]      src;
  logic [IDX_W-1:0]      src_end;
  logic                  shift_up;
  logic                  rd_active;
  logic                  wr_valid;
  logic [IDX_W-1:0]      wr_addr;
  logic                  place_pending;
  logic [IDX_W-1:0]      place_addr;
  logic [DATA_WIDTH-1:0] place_item;
  status_t               res_status;

  logic                  full;
  logic                  empty;
  logic                  at_last;
  logic [CNT_W-1:0]      total_m1;
  status_t               st_next;
  logic [CNT_W-1:0]      total_next;
  logic [IDX_W-1:0]      cursor_next;
  logic                  need_shift;
  logic                  need_place;
  logic                  up_next;
  logic [IDX_W-1:0]      start_next;
  logic [IDX_W-1:0]      end_next;
  logic [IDX_W-1:0]      paddr_next;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign empty    = (total == '0);
  assign full     = (total == CNT_W'(MAX_ENTRIES)) || (CMP_W'(total) >= CMP_W'(capacity));
  assign total_m1 = total - CNT_W'(1);
  assign at_last  = (CNT_W'(cursor) == total_m1);

  always_comb begin
    st_next     = ST_OK;
    total_next  = total;
    cursor_next = cursor;
    need_shift  = 1'b0;
    need_place  = 1'b0;
    up_next     = 1'b1;
    start_next  = src;
    end_next    = src_end;
    paddr_next  = cursor;
    unique case (op_t'(op))
      OP_INSERT: begin
        if (full) begin
          st_next = ST_FULL;
        end else if (empty || at_last) begin
          need_place  = 1'b1;
          paddr_next  = IDX_W'(total);
          cursor_next = IDX_W'(total);
          total_next  = total + CNT_W'(1);
        end else begin
          need_shift = 1'b1;
          need_place = 1'b1;
          start_next = IDX_W'(total_m1);
          end_next   = cursor;
          total_next = total + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          need_shift = (CNT_W'(cursor) + CNT_W'(1)) < total;
          up_next    = 1'b0;
          start_next = cursor + IDX_W'(1);
          end_next   = IDX_W'(total_m1);
          total_next = total_m1;
          if (total_m1 == '0) begin
            cursor_next = '0;
          end else if (CNT_W'(cursor) >= total_m1) begin
            cursor_next = IDX_W'(total_m1 - CNT_W'(1));
          end
        end
      end
      OP_REPLACE: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          need_place = 1'b1;
        end
      end
      OP_CLEAR: begin
        total_next  = '0;
        cursor_next = '0;
      end
      OP_BEGIN: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          cursor_next = '0;
        end
      end
      OP_END: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          cursor_next = IDX_W'(total_m1);
        end
      end
      OP_NEXT: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else if ((CNT_W'(cursor) + CNT_W'(1)) >= total) begin
          st_next = ST_BOUND;
        end else begin
          cursor_next = cursor + IDX_W'(1);
        end
      end
      OP_PRIOR: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else if (cursor == '0) begin
          st_next = ST_BOUND;
        end else begin
          cursor_next = cursor - IDX_W'(1);
        end
      end
      OP_READ: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      total         <= '0;
      cursor        <= '0;
      rd_active     <= 1'b0;
      wr_valid      <= 1'b0;
      place_pending <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.accept) begin
        rd_active     <= need_shift;
        wr_valid      <= 1'b0;
        src           <= start_next;
        src_end       <= end_next;
        shift_up      <= up_next;
        place_pending <= need_place;
        place_addr    <= paddr_next;
        place_item    <= DATA_WIDTH'(item);
        res_status    <= st_next;
        total         <= total_next;
        cursor        <= cursor_next;
      end
      if (cmd.shift_step) begin
        rd_active <= rd_active && (src != src_end);
        wr_valid  <= rd_active;
        wr_addr   <= shift_up ? src + IDX_W'(1) : src - IDX_W'(1);
        src       <= shift_up ? src - IDX_W'(1) : src + IDX_W'(1);
      end
      if (cmd.place) begin
        place_pending <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid       <= 1'b1;
        status          <= res_status;
        cursor_position <= empty ? '1 : 7'(cursor);
        read_value      <= empty ? '0 : 8'(ram_rdata);
        entry_count     <= 6'(total);
        is_full         <= full;
        is_empty        <= empty;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ram_we    = (cmd.shift_step && wr_valid) || cmd.place;
  assign ram_waddr = cmd.place ? place_addr : wr_addr;
  assign ram_wdata = cmd.place ? place_item : ram_rdata;
  assign ram_re    = (cmd.shift_step && rd_active) || cmd.fetch;
  assign ram_raddr = cmd.fetch ? cursor : src;

  cal_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign stat.need_shift    = need_shift;
  assign stat.need_place    = need_place;
  assign stat.shift_active  = rd_active;
  assign stat.place_pending = place_pending;
  assign stat.out_free      = !out_valid || !out_stall;

endmodule

// File: rtl/core/cal_ctrl.sv
module cal_ctrl
  import cal_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  cal_stat_t stat,
  output cal_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_FETCH,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          if (stat.need_shift) begin
            state_next = S_SHIFT;
          end else if (stat.need_place) begin
            state_next = S_PLACE;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (!stat.shift_active) begin
          state_next = stat.place_pending ? S_PLACE : S_FETCH;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

// File: rtl/core/cursor_array_list_core.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    op, item
// out      output     out_valid / out_stall  status, cursor_position, read_value,
//                                            entry_count, is_full, is_empty
// cfg      input      cfg_valid / cfg_ready  cfg_data (list capacity)
//
// Each command is accepted, then fetches the cursor entry and loads the output; an entry
// write (insert, replace) adds a place step. Entry moves (insert in the middle, remove
// before the end) go one entry a cycle through the single-write, single-read entry RAM.
// Reset (rst, synchronous) empties the list and sets the capacity to 63; no clearing pass.
// A stalled result holds in the output register; the next command is taken meanwhile
// and waits only at its own output load.
module cursor_array_list_core
  import cal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        op,
  input  logic [7:0]        item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic signed [6:0] cursor_position,
  output logic [7:0]        read_value,
  output logic [5:0]        entry_count,
  output logic              is_full,
  output logic              is_empty,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [5:0]        cfg_data
);

  cal_cmd_t  cmd;
  cal_stat_t stat;

  assign cfg_ready = 1'b1;

  cal_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  cal_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .item           (item),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .cursor_position(cursor_position),
    .read_value     (read_value),
    .entry_count    (entry_count),
    .is_full        (is_full),
    .is_empty       (is_empty)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command taken while another is in progress");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (read_value == 8'd0) && (cursor_position == -7'sd1)
                              && (entry_count == 6'd0))
    else $error("empty list result is inconsistent");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_empty |-> !cursor_position[6] && (cursor_position[5:0] < entry_count))
    else $error("cursor outside the list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> is_full)
    else $error("full status on a list that is not full");

endmodule
